>>> rtl/q2e_pkg.sv
// Shared widths, the inter-stage word and the CORDIC angle table for the
// quaternion to Euler bin converter. No dependencies.
`default_nettype none
package q2e_pkg;

  localparam int QW         = 16;   // quaternion component
  localparam int MW         = 32;   // 16x16 product
  localparam int PW         = 34;   // doubled product sums
  localparam int SW         = 30;   // clamped pitch argument
  localparam int CW         = 29;   // cosine, 0 .. 2^28
  localparam int VW         = 58;   // sqrt radicand and remainder
  localparam int XW         = 37;   // CORDIC x / y
  localparam int ZW         = 34;   // CORDIC angle
  localparam int ITER       = 32;   // CORDIC iterations
  localparam int SQ_STEPS   = 29;   // result bits of the square root
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int BW         = 5;    // bin width

  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
  localparam logic signed [PW-1:0] ONE_Q28      = PW'(64'sd268435456);

  typedef struct packed {
    logic signed [PW-1:0] rn;
    logic signed [PW-1:0] rd;
    logic signed [PW-1:0] yn;
    logic signed [PW-1:0] yd;
    logic signed [SW-1:0] s;
    logic        [CW-1:0] c;
  } front_word_t;

  // atan(2^-i) with a full turn of 2^32
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/q2e_front.sv
// Front pipeline: component products, product sums, pitch clamp and the
// bit-per-stage square root for the pitch cosine. Uses q2e_pkg.
`default_nettype none
module q2e_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [q2e_pkg::QW-1:0] qw,
  input  wire logic signed [q2e_pkg::QW-1:0] qx,
  input  wire logic signed [q2e_pkg::QW-1:0] qy,
  input  wire logic signed [q2e_pkg::QW-1:0] qz,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output q2e_pkg::front_word_t               out_word
);

  localparam int NS = 3 + q2e_pkg::SQ_STEPS;
  localparam int MW = q2e_pkg::MW;
  localparam int PW = q2e_pkg::PW;
  localparam int SW = q2e_pkg::SW;
  localparam int CW = q2e_pkg::CW;
  localparam int VW = q2e_pkg::VW;

  logic [NS-1:0] vld;
  logic          en;

  assign en        = !vld[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // stage 1: products
  logic signed [MW-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
  end

  // stage 2: sums and pitch clamp
  logic signed [PW-1:0] s_raw, s_cl;
  logic signed [PW-1:0] rn2, rd2, yn2, yd2;
  logic signed [SW-1:0] s2;

  always_comb begin
    s_raw = (PW'(p_wy) - PW'(p_zx)) <<< 1;
    s_cl  = s_raw;
    if (s_raw > q2e_pkg::ONE_Q28) s_cl = q2e_pkg::ONE_Q28;
    if (s_raw < -q2e_pkg::ONE_Q28) s_cl = -q2e_pkg::ONE_Q28;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn2 <= (PW'(p_wx) + PW'(p_yz)) <<< 1;
      rd2 <= q2e_pkg::ONE_Q28 - ((PW'(p_xx) + PW'(p_yy)) <<< 1);
      yn2 <= (PW'(p_wz) + PW'(p_xy)) <<< 1;
      yd2 <= q2e_pkg::ONE_Q28 - ((PW'(p_yy) + PW'(p_zz)) <<< 1);
      s2  <= SW'(s_cl);
    end
  end

  // stage 3: radicand 2^56 - s*s
  logic [CW-1:0] s_abs;
  logic [VW-1:0] s_sq;
  assign s_abs = s2[SW-1] ? CW'(-s2) : CW'(s2);
  assign s_sq  = VW'(s_abs) * VW'(s_abs);

  q2e_pkg::front_word_t wrd [q2e_pkg::SQ_STEPS+1];
  logic [VW-1:0]        rem [q2e_pkg::SQ_STEPS+1];
  logic [CW-1:0]        root[q2e_pkg::SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]     <= (VW'(1) << 56) - s_sq;
      root[0]    <= '0;
      wrd[0].rn  <= rn2;
      wrd[0].rd  <= rd2;
      wrd[0].yn  <= yn2;
      wrd[0].yd  <= yd2;
      wrd[0].s   <= s2;
      wrd[0].c   <= '0;
    end
  end

  // square root, one result bit per stage, most significant first
  for (genvar k = 0; k < q2e_pkg::SQ_STEPS; k++) begin : g_sqrt
    localparam int B = q2e_pkg::SQ_STEPS - 1 - k;
    logic [VW-1:0] trial;
    assign trial = (VW'(root[k]) << (B + 1)) + (VW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        wrd[k+1] <= wrd[k];
        if (rem[k] >= trial) begin
          rem[k+1]  <= rem[k] - trial;
          root[k+1] <= root[k] | (CW'(1) << B);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  always_comb begin
    out_word   = wrd[q2e_pkg::SQ_STEPS];
    out_word.c = root[q2e_pkg::SQ_STEPS];
  end

endmodule
`default_nettype wire

>>> rtl/q2e_fifo.sv
// Short queue between the front and back pipelines. Holds front_word_t
// entries from q2e_pkg in a small register array.
`default_nettype none
module q2e_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire q2e_pkg::front_word_t din,
  output logic                      full,
  input  wire logic                 pop,
  output q2e_pkg::front_word_t      dout,
  output logic                      empty
);

  localparam int AW = q2e_pkg::FIFO_AW;

  q2e_pkg::front_word_t mem[q2e_pkg::FIFO_DEPTH];
  logic [AW-1:0]        wptr, rptr;
  logic [AW:0]          count;

  assign full  = count == (AW+1)'(q2e_pkg::FIFO_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && !empty) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= din;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(q2e_pkg::FIFO_DEPTH))
    else $error("queue count above depth");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> full)
    else $error("full queue changed without a pop");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !push) |=> count == $past(count) - 1'b1)
    else $error("pop did not reduce count");

endmodule
`default_nettype wire

>>> rtl/q2e_cordic.sv
// One vectoring CORDIC lane: atan2(ny, dx) as a binary angle, with the
// zero-numerator and zero-denominator cases. Uses q2e_pkg.
`default_nettype none
module q2e_cordic (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [q2e_pkg::PW-1:0] ny,
  input  wire logic signed [q2e_pkg::PW-1:0] dx,
  output logic signed [q2e_pkg::ZW-1:0]      angle
);

  localparam int XW = q2e_pkg::XW;
  localparam int ZW = q2e_pkg::ZW;
  localparam int N  = q2e_pkg::ITER;

  logic signed [XW-1:0] x[N+1];
  logic signed [XW-1:0] y[N+1];
  logic signed [ZW-1:0] z[N+1];
  logic                 fix[N+1];
  logic signed [ZW-1:0] fang[N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      fix[0]  <= (ny == '0) || (dx == '0);
      if (ny == '0) begin
        fang[0] <= dx[q2e_pkg::PW-1] ? q2e_pkg::HALF_TURN : '0;
      end else begin
        fang[0] <= ny[q2e_pkg::PW-1] ? -q2e_pkg::QUARTER_TURN : q2e_pkg::QUARTER_TURN;
      end
      if (dx[q2e_pkg::PW-1]) begin
        x[0] <= -XW'(dx);
        y[0] <= -XW'(ny);
        z[0] <= ny[q2e_pkg::PW-1] ? -q2e_pkg::HALF_TURN : q2e_pkg::HALF_TURN;
      end else begin
        x[0] <= XW'(dx);
        y[0] <= XW'(ny);
        z[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] tab;
    assign xs  = x[k] >>> k;
    assign ys  = y[k] >>> k;
    assign tab = ZW'(q2e_pkg::atan_entry(5'(k)));
    always_ff @(posedge clk) begin
      if (en) begin
        fix[k+1]  <= fix[k];
        fang[k+1] <= fang[k];
        if (!y[k][XW-1]) begin
          x[k+1] <= x[k] + ys;
          y[k+1] <= y[k] - xs;
          z[k+1] <= z[k] + tab;
        end else begin
          x[k+1] <= x[k] - ys;
          y[k+1] <= y[k] + xs;
          z[k+1] <= z[k] - tab;
        end
      end
    end
  end

  assign angle = fix[N] ? fang[N] : z[N];

endmodule
`default_nettype wire

>>> rtl/q2e_back.sv
// Back pipeline: three CORDIC lanes (q2e_cordic), binning and the output
// register. Pulls words from the queue. Uses q2e_pkg.
`default_nettype none
module q2e_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  input  wire q2e_pkg::front_word_t   q_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [q2e_pkg::BW-1:0]      roll_bin,
  output logic [q2e_pkg::BW-1:0]      pitch_bin,
  output logic [q2e_pkg::BW-1:0]      yaw_bin
);

  localparam int ZW = q2e_pkg::ZW;
  localparam int PW = q2e_pkg::PW;
  localparam int NL = 1 + q2e_pkg::ITER;

  function automatic logic [q2e_pkg::BW-1:0] to_bin(input logic signed [ZW-1:0] a,
                                                    input logic pitch);
    logic signed [ZW-1:0] h, c;
    logic [ZW+4:0]        u, p;
    h = pitch ? q2e_pkg::QUARTER_TURN : q2e_pkg::HALF_TURN;
    c = a;
    if (a > h) c = h;
    if (a < -h) c = -h;
    u = (ZW+5)'(c + h);
    p = (u << 4) + (u << 1);
    return pitch ? q2e_pkg::BW'(p >> 31) : q2e_pkg::BW'(p >> 32);
  endfunction

  logic          en;
  logic [NL-1:0] vld;
  logic signed [ZW-1:0] a_roll, a_pitch, a_yaw;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NL-2:0], !q_empty};
      out_valid <= vld[NL-1];
    end
  end

  q2e_cordic u_roll  (.clk(clk), .en(en), .ny(q_word.rn), .dx(q_word.rd), .angle(a_roll));
  q2e_cordic u_pitch (.clk(clk), .en(en), .ny(PW'(q_word.s)), .dx(PW'(q_word.c)),
                      .angle(a_pitch));
  q2e_cordic u_yaw   (.clk(clk), .en(en), .ny(q_word.yn), .dx(q_word.yd), .angle(a_yaw));

  always_ff @(posedge clk) begin
    if (en) begin
      roll_bin  <= to_bin(a_roll, 1'b0);
      pitch_bin <= to_bin(a_pitch, 1'b1);
      yaw_bin   <= to_bin(a_yaw, 1'b0);
    end
  end

endmodule
`default_nettype wire

>>> rtl/quaternion_to_euler_bins.sv
// Quaternion (Q1.14) to ZYX Euler angle bins, top level.
// Instantiates q2e_front, q2e_fifo and q2e_back; uses q2e_pkg.
//
// Usage: push one quaternion per word on s_axis (w, x, y, z, 16 bits each,
// w lowest). Each word yields one m_axis word with roll, pitch and yaw
// bins 0..18 (5 bits each, roll lowest).
// Throughput: one word per cycle, sustained, when m_axis is ready.
// Path from accept to m_axis_tvalid: the front pipeline (products, sums,
// radicand, 29 square-root stages), the queue's register array, the CORDIC
// lanes in the back pipeline and one output register.
// The front and back pipelines advance independently; a 4-word queue
// between them absorbs short stalls. When m_axis_tready is low with a word
// on m_axis, the back pipeline holds, the queue fills, and then s_axis_tready drops.
// Reset (rst, synchronous) empties all pipelines and the queue; the block
// keeps no other state.
`default_nettype none
module quaternion_to_euler_bins (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // roll_bin, pitch_bin, yaw_bin, zero pad
);

  logic                 f_valid, q_full, q_empty, q_pop;
  q2e_pkg::front_word_t f_word, q_word;
  logic [q2e_pkg::BW-1:0] roll_bin, pitch_bin, yaw_bin;

  q2e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .qw       (s_axis_tdata[15:0]),
    .qx       (s_axis_tdata[31:16]),
    .qy       (s_axis_tdata[47:32]),
    .qz       (s_axis_tdata[63:48]),
    .out_valid(f_valid),
    .out_ready(!q_full),
    .out_word (f_word)
  );

  q2e_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (f_valid),
    .din  (f_word),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_word),
    .empty(q_empty)
  );

  q2e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_word   (q_word),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .roll_bin (roll_bin),
    .pitch_bin(pitch_bin),
    .yaw_bin  (yaw_bin)
  );

  assign m_axis_tdata = {1'b0, yaw_bin, pitch_bin, roll_bin};

endmodule
`default_nettype wire

>>> sim/euler_bin_checker.sv
// Checker for quaternion_to_euler_bins: watches both stream channels, predicts
// roll, pitch and yaw bins per accepted quaternion and compares in order.
// Depends on q2e_pkg for the CORDIC angle table.
module euler_bin_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_T = 64'sd2147483648;
  localparam longint QUART_T = 64'sd1073741824;
  localparam longint UNIT_Q28 = 64'sd268435456;

  typedef struct packed {
    logic [4:0] yaw;
    logic [4:0] pitch;
    logic [4:0] roll;
  } bins_t;

  bins_t bins_due[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint angle_of(longint ny, longint dx);
    longint xa, ya, za, xs, ys;
    xa = dx;
    ya = ny;
    za = 0;
    if (ny == 0) return (dx < 0) ? HALF_T : 0;
    if (dx == 0) return (ny > 0) ? QUART_T : -QUART_T;
    if (xa < 0) begin
      za = (ya > 0) ? HALF_T : -HALF_T;
      xa = -xa;
      ya = -ya;
    end
    for (int i = 0; i < 32; i++) begin
      xs = shr_floor(xa, i);
      ys = shr_floor(ya, i);
      if (ya >= 0) begin
        xa = xa + ys;
        ya = ya - xs;
        za = za + longint'(q2e_pkg::atan_entry(5'(i)));
      end else begin
        xa = xa - ys;
        ya = ya + xs;
        za = za - longint'(q2e_pkg::atan_entry(5'(i)));
      end
    end
    return za;
  endfunction

  function automatic logic [4:0] bin_of(longint a, longint h);
    if (a > h) a = h;
    if (a < -h) a = -h;
    return 5'(((a + h) * 18) / (2 * h));
  endfunction

  function automatic longint root_floor(longint v);
    longint r, t;
    r = 0;
    for (int b = 28; b >= 0; b--) begin
      t = r | (64'sd1 <<< b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic bins_t euler_bins(logic [63:0] q);
    longint w, x, y, z, rn, rd, yn, yd, s, c;
    bins_t b;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    rn = 2 * (w * x + y * z);
    rd = UNIT_Q28 - 2 * (x * x + y * y);
    yn = 2 * (w * z + x * y);
    yd = UNIT_Q28 - 2 * (y * y + z * z);
    s = 2 * (w * y - z * x);
    if (s > UNIT_Q28) s = UNIT_Q28;
    if (s < -UNIT_Q28) s = -UNIT_Q28;
    c = root_floor(UNIT_Q28 * UNIT_Q28 - s * s);
    b.roll = bin_of(angle_of(rn, rd), HALF_T);
    b.pitch = bin_of(angle_of(s, c), QUART_T);
    b.yaw = bin_of(angle_of(yn, yd), HALF_T);
    return b;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  assign pending = bins_due.size();

  initial err_count = 0;

  always @(posedge clk) begin
    bins_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) bins_due.push_back(euler_bins(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (bins_due.size() == 0) begin
          report("unexpected word", m_axis_tdata, 0);
        end else begin
          want = bins_due.pop_front();
          if (m_axis_tdata[4:0] != want.roll) report("roll", m_axis_tdata[4:0], want.roll);
          if (m_axis_tdata[9:5] != want.pitch)
            report("pitch", m_axis_tdata[9:5], want.pitch);
          if (m_axis_tdata[14:10] != want.yaw)
            report("yaw", m_axis_tdata[14:10], want.yaw);
          if (m_axis_tdata[15] != 1'b0) report("pad", m_axis_tdata[15], 0);
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
// Top of the quaternion_to_euler_bins testbench: clock, reset, quaternion
// stimulus with idle phases, watchdog and verdict. Uses euler_bin_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 67;
  localparam int WATCHDOG = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int          err_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quaternion_to_euler_bins u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  euler_bin_checker u_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .err_count(err_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // count cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // near-unit quaternion: scale random directions so the sum of squares is ~1
  function automatic logic [63:0] unit_quat();
    real c[4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = $itor($signed($urandom_range(2000))) - 1000.0;
      n += c[i] * c[i];
    end
    if (n == 0.0) return 64'd16384;
    n = $sqrt(n);
    return {16'($rtoi(c[3] / n * 16383.0)), 16'($rtoi(c[2] / n * 16383.0)),
            16'($rtoi(c[1] / n * 16383.0)), 16'($rtoi(c[0] / n * 16383.0))};
  endfunction

  task automatic send(logic [63:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= q;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0] directed[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity, axis rotations, gimbal lock both ways, extremes, zero, half turns
    directed = '{64'h0000_0000_0000_4000, 64'h0000_0000_4000_0000,
                 64'h0000_4000_0000_0000, 64'h4000_0000_0000_0000,
                 64'h0000_2D41_0000_2D41, 64'h0000_D2BF_0000_2D41,
                 64'h0000_0000_0000_0000, 64'hC000_C000_C000_C000,
                 64'h4000_4000_4000_4000, 64'h8000_8000_8000_8000,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h0000_0000_0000_C000,
                 64'h0000_0000_C000_0000, 64'h2000_2000_2000_2000,
                 64'hE000_2000_E000_2000, 64'h0000_0001_0000_0000,
                 64'h0001_0000_0000_0000, 64'h0000_0000_0001_0000,
                 64'h0000_0000_FFFF_0000, 64'hFFFF_0000_0000_0000,
                 64'h0000_4000_4000_0000, 64'h4000_0000_0000_4000};
    foreach (directed[i]) send(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 18) : 0;
      recv_stall_pct = (ph == 2) ? 51 : ((ph == 3) ? 18 : 0);
      for (int n = 0; n < 160; n++) begin
        if ($urandom_range(9) < 8)
          send(unit_quat());
        else
          send({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
      end
      if (ph == 1) begin
        // hold off until the pipeline has drained
        go_idle();
        while (pending != 0) @(posedge clk);
      end
    end
    go_idle();

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule

>>> sim.f
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_fifo.sv
rtl/q2e_cordic.sv
rtl/q2e_back.sv
rtl/quaternion_to_euler_bins.sv
sim/euler_bin_checker.sv
sim/testbench.sv
